FILE: hdl/tfp_pkg.sv
// tfp_pkg: types, frame codes and header constants of the telemetry frame parser.
// No dependencies; the top level, tfp_front, tfp_fifo and tfp_back import it.
`default_nettype none

package tfp_pkg;

  // Header and type bytes
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_T      = 8'h54;  // 'T'
  localparam logic [7:0] CH_GPS    = 8'h47;  // 'G'
  localparam logic [7:0] CH_ATT    = 8'h41;  // 'A'
  localparam logic [7:0] CH_SEN    = 8'h53;  // 'S'

  localparam int unsigned PAYLOAD_MAX = 14;
  localparam int unsigned CNT_W       = 4;

  localparam logic [CNT_W-1:0] LEN_GPS = 4'd14;
  localparam logic [CNT_W-1:0] LEN_ATT = 4'd6;
  localparam logic [CNT_W-1:0] LEN_SEN = 4'd7;

  localparam logic [1:0]  FIX_MASK     = 2'b11;
  localparam logic [31:0] HEADING_WRAP = 32'd360;

  typedef enum logic [1:0] {
    KIND_GPS = 2'd0,
    KIND_ATT = 2'd1,
    KIND_SEN = 2'd2
  } kind_t;

  // One checked frame handed from the front end to the decoder
  typedef struct packed {
    kind_t                            kind;
    logic [PAYLOAD_MAX-1:0][7:0]      bytes;
  } frame_t;

  // Decoded result as held in the output register
  typedef struct packed {
    logic [1:0]         frame_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
    logic [7:0]         speed_byte;
    logic [5:0]         sat_count;
    logic [1:0]         fix_type;
  } result_t;

  // Payload length of a frame kind; unused code falls back to the GPS length
  function automatic logic [CNT_W-1:0] body_len(input kind_t k);
    logic [CNT_W-1:0] len;
    case (k)
      KIND_GPS: len = LEN_GPS;
      KIND_ATT: len = LEN_ATT;
      KIND_SEN: len = LEN_SEN;
      default:  len = LEN_GPS;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tfp_in_if.sv
// tfp_in_if: byte channel into the parser (valid, ready, one stream byte).
// No dependencies.
`default_nettype none

interface tfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/tfp_out_if.sv
// tfp_out_if: decoded result channel out of the parser.
// No dependencies.
`default_nettype none

interface tfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic signed [31:0] third_value;
  logic [7:0]         speed_byte;
  logic [5:0]         sat_count;
  logic [1:0]         fix_type;

  modport source (output valid, output frame_kind, output first_value, output second_value,
                  output third_value, output speed_byte, output sat_count,
                  output fix_type, input ready);
  modport sink   (input valid, input frame_kind, input first_value, input second_value,
                  input third_value, input speed_byte, input sat_count,
                  input fix_type, output ready);
endinterface

`default_nettype wire

FILE: hdl/telemetry_frame_parser.sv
// telemetry_frame_parser: top level, front end + frame queue + decoder.
// Depends on tfp_pkg, tfp_in_if, tfp_out_if, tfp_front, tfp_fifo, tfp_back.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   data_byte[7:0]
//   out_ch   out  valid/ready   frame_kind, first/second/third_value, speed_byte,
//                               sat_count, fix_type
//
// One byte is taken per cycle while the frame queue has room; the parser state machine is registered.
// A good frame is queued at the edge that takes its checksum byte and then shows
// on out_ch once the decoder's output register takes it; that register waits while out_ch stalls.
// Synchronous active-low reset returns the parser to the header hunt and
// empties the queue; payload storage is not cleared.
// in_ch stalls only while the frame queue (QUEUE_DEPTH frames) is full.
`default_nettype none

module telemetry_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tfp_in_if.sink     in_ch,
  tfp_out_if.source  out_ch
);
  import tfp_pkg::*;

  logic    push_valid, push_ready;
  frame_t  push_data;
  logic    pop_valid, pop_ready;
  frame_t  pop_data;
  result_t res_data;

  tfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_ready (in_ch.ready),
    .byte_data  (in_ch.data_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tfp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_data  (res_data)
  );

  assign out_ch.frame_kind   = res_data.frame_kind;
  assign out_ch.first_value  = res_data.first_value;
  assign out_ch.second_value = res_data.second_value;
  assign out_ch.third_value  = res_data.third_value;
  assign out_ch.speed_byte   = res_data.speed_byte;
  assign out_ch.sat_count    = res_data.sat_count;
  assign out_ch.fix_type     = res_data.fix_type;

endmodule

`default_nettype wire

FILE: hdl/tfp_front.sv
// tfp_front: header hunt, payload capture and XOR check; pushes good frames.
// Depends on tfp_pkg.
`default_nettype none

module tfp_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           byte_valid,
  output logic                byte_ready,
  input  wire logic [7:0]     byte_data,
  output logic                push_valid,
  input  wire logic           push_ready,
  output tfp_pkg::frame_t     push_data
);
  import tfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DOLLAR = 4'b0010,
    ST_TEE    = 4'b0100,
    ST_BODY   = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  kind_t                       kind_r, kind_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [PAYLOAD_MAX-1:0][7:0] store_r;
  logic                        accept;
  logic                        store_en;

  // A beat is taken whenever the queue has room for a possible frame
  assign byte_ready = push_ready;
  assign accept     = byte_valid && push_ready;

  // Parser state update
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    store_en   = 1'b0;
    push_valid = 1'b0;
    if (accept) begin
      case (state_r)
        ST_IDLE: begin
          if (byte_data == CH_DOLLAR) state_nxt = ST_DOLLAR;
        end
        ST_DOLLAR: begin
          // a second '$' does not restart the hunt
          state_nxt = (byte_data == CH_T) ? ST_TEE : ST_IDLE;
        end
        ST_TEE: begin
          count_nxt = '0;
          xor_nxt   = '0;
          state_nxt = ST_BODY;
          case (byte_data)
            CH_GPS:  kind_nxt = KIND_GPS;
            CH_ATT:  kind_nxt = KIND_ATT;
            CH_SEN:  kind_nxt = KIND_SEN;
            default: state_nxt = ST_IDLE;
          endcase
        end
        ST_BODY: begin
          xor_nxt = xor_r ^ byte_data;
          if (count_r >= body_len(kind_r)) begin
            // checksum beat: frame is good when everything XORs to zero
            state_nxt  = ST_IDLE;
            push_valid = (xor_nxt == 8'd0);
          end else begin
            store_en  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_GPS;
      count_r <= '0;
      xor_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (store_en) store_r[count_r] <= byte_data;
  end

  assign push_data.kind  = kind_r;
  assign push_data.bytes = store_r;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("frame pushed into a full queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY) |-> (count_r <= body_len(kind_r)))
    else $error("payload count ran past the frame length");
`endif

endmodule

`default_nettype wire

FILE: hdl/tfp_fifo.sv
// tfp_fifo: short frame queue between the front end and the decoder.
// Depends on tfp_pkg.
`default_nettype none

module tfp_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire tfp_pkg::frame_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output tfp_pkg::frame_t      pop_data
);
  import tfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  frame_t              mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Frame storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue occupancy above depth");
`endif

endmodule

`default_nettype wire

FILE: hdl/tfp_back.sv
// tfp_back: decodes a queued frame into result fields and holds the result register.
// Depends on tfp_pkg.
`default_nettype none

module tfp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire tfp_pkg::frame_t pop_data,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output tfp_pkg::result_t     res_data
);
  import tfp_pkg::*;

  logic    valid_r;
  result_t res_r;
  result_t dec;
  logic [31:0] head_ext;

  // Field decode, little endian
  always_comb begin
    dec            = '0;
    dec.frame_kind = 2'(pop_data.kind);
    head_ext       = {{16{pop_data.bytes[5][7]}}, pop_data.bytes[5], pop_data.bytes[4]};
    case (pop_data.kind)
      KIND_GPS: begin
        dec.first_value  = {pop_data.bytes[3], pop_data.bytes[2],
                            pop_data.bytes[1], pop_data.bytes[0]};
        dec.second_value = {pop_data.bytes[7], pop_data.bytes[6],
                            pop_data.bytes[5], pop_data.bytes[4]};
        dec.speed_byte   = pop_data.bytes[8];
        dec.third_value  = {pop_data.bytes[12], pop_data.bytes[11],
                            pop_data.bytes[10], pop_data.bytes[9]};
        dec.sat_count    = pop_data.bytes[13][7:2];
        dec.fix_type     = pop_data.bytes[13][1:0] & FIX_MASK;
      end
      KIND_ATT: begin
        dec.first_value  = {{16{pop_data.bytes[1][7]}}, pop_data.bytes[1], pop_data.bytes[0]};
        dec.second_value = {{16{pop_data.bytes[3][7]}}, pop_data.bytes[3], pop_data.bytes[2]};
        // a negative heading gets 360 added; only -360..-1 lands in 0..359
        dec.third_value  = head_ext[31] ? head_ext + HEADING_WRAP : head_ext;
      end
      default: begin
        // sensor frame; arm/mode byte is not reported
        dec.first_value  = {16'd0, pop_data.bytes[1], pop_data.bytes[0]};
        dec.second_value = {16'd0, pop_data.bytes[3], pop_data.bytes[2]};
        dec.third_value  = {24'd0, pop_data.bytes[4]};
        dec.speed_byte   = pop_data.bytes[5];
      end
    endcase
  end

  // Output register: refills in the same cycle the held beat leaves
  assign pop_ready = !valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) res_r <= dec;
  end

  assign res_valid = valid_r;
  assign res_data  = res_r;

`ifndef SYNTHESIS
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (res_r.frame_kind != 2'd3))
    else $error("result carries an unused frame kind");
`endif

endmodule

`default_nettype wire
